// ===== hw/rtl/pics_pkg.sv =====
package pics_pkg;

  // default table geometry
  localparam int MAX_SECTORS_DEF = 16;
  localparam int MAX_FACES_DEF   = 16;

  // fixed field widths
  localparam int SEL_W   = 4;
  localparam int NRM_W   = 18;
  localparam int CRD_W   = 24;
  localparam int PNT_W   = CRD_W + 1;        // point minus origin
  localparam int PROD_W  = NRM_W + PNT_W;    // one product
  localparam int OFS_W   = 44;               // stored plane offset
  localparam int SUM_W   = 45;               // three-term dot product
  localparam int CNT_W   = 5;                // sector_count register
  localparam int STAT_W  = 2;
  localparam int HIT_W   = 4;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SECTOR_COUNT = 2'd0,
    REG_ORIGIN_X     = 2'd1,
    REG_ORIGIN_Y     = 2'd2,
    REG_ORIGIN_Z     = 2'd3
  } pics_cfg_reg_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_STORED  = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_INSIDE  = 2'd2,
    STAT_OUTSIDE = 2'd3
  } pics_status_e;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } pics_func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_CHK,
    S_MAC,
    S_LD_WR,
    S_Q_SEC,
    S_Q_CMP,
    S_DONE
  } pics_state_e;

  // one stored face plane
  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [OFS_W-1:0] ofs;
  } pics_plane_t;

  // sequencer control into the multiply-accumulate unit
  typedef struct packed {
    logic step;    // take one product this cycle
    logic first;   // first term of a new dot product
  } pics_mac_ctl_t;

endpackage

// ===== hw/rtl/pics_mac.sv =====
module pics_mac
  import pics_pkg::*;
(
  input  logic                     clk_i,
  input  pics_mac_ctl_t            ctl_i,
  input  logic signed [NRM_W-1:0]  nrm_i,
  input  logic signed [PNT_W-1:0]  crd_i,
  input  logic signed [OFS_W-1:0]  ofs_i,
  output logic signed [SUM_W-1:0]  sum_o,
  output logic                     gt_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  // registered product, added into the accumulator when the following term is taken
  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      prod_q <= nrm_i * crd_i;
      acc_q  <= ctl_i.first ? '0 : acc_q + SUM_W'(prod_q);
    end
  end

  // last term folded in here; compare against the face offset
  assign sum_o = acc_q + SUM_W'(prod_q);
  assign gt_o  = sum_o > SUM_W'(ofs_i);

endmodule

// ===== hw/rtl/point_in_convex_sectors.sv =====
// Load word: check, 3 MAC steps, write, then result; a refused load goes from the check to
//   the result. Query word: a sector check per sector visited, plus one when no sector
//   holds the point, and for each face tested 3 MAC steps and a compare; one shared 18x25
//   multiplier takes three products per face.
// One word in flight; the next word is accepted once the result sits in the output register.
// Reset clears face counts, configuration and control state; the plane store is never cleared.
module point_in_convex_sectors
  import pics_pkg::*;
#(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  parameter int MAX_FACES   = MAX_FACES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sector_sel[3:0], normal_x[21:4], normal_y[39:22], normal_z[57:40],
  // coord_x[81:58], coord_y[105:82], coord_z[129:106], zero fill
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                    s_axis_tuser,   // func[0]
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // hit_sector[3:0], zero fill
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [STAT_W-1:0]       m_axis_tuser,   // status[1:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CRD_W-1:0]        cfg_data_i
);

  localparam int DEPTH = MAX_SECTORS * MAX_FACES;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int SCW   = $clog2(MAX_SECTORS + 1);
  localparam int FW    = $clog2(MAX_FACES);
  localparam int FCW   = $clog2(MAX_FACES + 1);
  localparam int LW    = (SCW > CNT_W) ? SCW : CNT_W;

  // input word fields
  logic [SEL_W-1:0]        in_sel;
  logic signed [NRM_W-1:0] in_nrm [3];
  logic signed [CRD_W-1:0] in_crd [3];

  assign in_sel    = s_axis_tdata[3:0];
  assign in_nrm[0] = s_axis_tdata[21:4];
  assign in_nrm[1] = s_axis_tdata[39:22];
  assign in_nrm[2] = s_axis_tdata[57:40];
  assign in_crd[0] = s_axis_tdata[81:58];
  assign in_crd[1] = s_axis_tdata[105:82];
  assign in_crd[2] = s_axis_tdata[129:106];

  // configuration
  logic [CNT_W-1:0]        sector_count_q;
  logic signed [CRD_W-1:0] origin_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q <= '0;
      origin_q[0]    <= '0;
      origin_q[1]    <= '0;
      origin_q[2]    <= '0;
    end else if (cfg_valid_i) begin
      unique case (pics_cfg_reg_e'(cfg_addr_i))
        REG_SECTOR_COUNT: sector_count_q <= cfg_data_i[CNT_W-1:0];
        REG_ORIGIN_X:     origin_q[0]    <= cfg_data_i;
        REG_ORIGIN_Y:     origin_q[1]    <= cfg_data_i;
        REG_ORIGIN_Z:     origin_q[2]    <= cfg_data_i;
      endcase
    end
  end

  // sequencer state
  pics_state_e             state_q, state_d;
  pics_func_e              func_q;
  logic [SEL_W-1:0]        sel_q;
  logic signed [NRM_W-1:0] nrm_q [3];
  logic signed [PNT_W-1:0] crd_q [3];
  logic [1:0]              ph_q, ph_d;
  logic [SCW-1:0]          s_q, s_d;
  logic [FCW-1:0]          f_q, f_d;
  logic [BW-1:0]           base_q, base_d;
  pics_status_e            stat_q, stat_d;
  logic [HIT_W-1:0]        hit_q, hit_d;
  logic                    out_vld_q;
  pics_status_e            out_stat_q;
  logic [HIT_W-1:0]        out_hit_q;

  logic                    in_acc;
  logic                    out_load;
  logic                    out_free;

  // face counts and plane store
  logic [FCW-1:0]          face_cnt_q [MAX_SECTORS];
  logic [SW-1:0]           cnt_idx;
  logic [FCW-1:0]          cnt_rd;
  logic                    cnt_we;
  pics_plane_t             plane_mem [DEPTH];
  pics_plane_t             rd_q;
  pics_plane_t             wr_data;
  logic                    rd_en;
  logic                    mem_we;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  // shared multiply-accumulate
  pics_mac_ctl_t           mac_ctl;
  logic signed [NRM_W-1:0] mac_nrm;
  logic signed [PNT_W-1:0] mac_crd;
  logic signed [SUM_W-1:0] mac_sum;
  logic                    mac_gt;

  logic                    sel_bad;
  logic                    sec_end;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // load addresses one sector, a query walks the current sector
  assign cnt_idx = (func_q == FUNC_QUERY) ? SW'(s_q) : SW'(sel_q);
  assign cnt_rd  = face_cnt_q[cnt_idx];
  assign sel_bad = (LW'(sel_q) >= LW'(MAX_SECTORS));
  assign sec_end = (LW'(s_q) >= LW'(sector_count_q)) || (LW'(s_q) >= LW'(MAX_SECTORS));
  assign wr_addr = AW'(BW'(cnt_idx) * BW'(MAX_FACES) + BW'(cnt_rd));

  // capture the word; a query moves the point to the volume origin
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sel_q <= in_sel;
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= in_nrm[i];
        crd_q[i] <= s_axis_tuser ? PNT_W'(in_crd[i]) - PNT_W'(origin_q[i])
                                 : PNT_W'(in_crd[i]);
      end
    end
  end

  // operand select for the current component
  always_comb begin
    unique case (ph_q)
      2'd0: begin
        mac_nrm = (func_q == FUNC_QUERY) ? rd_q.nx : nrm_q[0];
        mac_crd = crd_q[0];
      end
      2'd1: begin
        mac_nrm = (func_q == FUNC_QUERY) ? rd_q.ny : nrm_q[1];
        mac_crd = crd_q[1];
      end
      default: begin
        mac_nrm = (func_q == FUNC_QUERY) ? rd_q.nz : nrm_q[2];
        mac_crd = crd_q[2];
      end
    endcase
  end

  pics_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .nrm_i (mac_nrm),
    .crd_i (mac_crd),
    .ofs_i (rd_q.ofs),
    .sum_o (mac_sum),
    .gt_o  (mac_gt)
  );

  always_comb begin
    wr_data.nx  = nrm_q[0];
    wr_data.ny  = nrm_q[1];
    wr_data.nz  = nrm_q[2];
    wr_data.ofs = mac_sum[OFS_W-1:0];
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= FUNC_LOAD;
      ph_q    <= '0;
      s_q     <= '0;
      f_q     <= '0;
      base_q  <= '0;
      stat_q  <= STAT_STORED;
      hit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) func_q <= pics_func_e'(s_axis_tuser);
      ph_q    <= ph_d;
      s_q     <= s_d;
      f_q     <= f_d;
      base_q  <= base_d;
      stat_q  <= stat_d;
      hit_q   <= hit_d;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    s_d      = s_q;
    f_d      = f_q;
    base_d   = base_q;
    stat_d   = stat_q;
    hit_d    = hit_q;
    mac_ctl  = '0;
    rd_en    = 1'b0;
    rd_addr  = AW'(base_q);
    mem_we   = 1'b0;
    cnt_we   = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          s_d    = '0;
          f_d    = '0;
          base_d = '0;
          ph_d   = '0;
          hit_d  = '0;
          state_d = s_axis_tuser ? S_Q_SEC : S_LD_CHK;
        end
      end
      S_LD_CHK: begin
        priority if (sel_bad || (cnt_rd >= FCW'(MAX_FACES))) begin
          stat_d  = STAT_REFUSED;
          state_d = S_DONE;
        end else begin
          ph_d    = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        mac_ctl.step  = 1'b1;
        mac_ctl.first = (ph_q == 2'd0);
        if (ph_q == 2'd2) begin
          state_d = (func_q == FUNC_QUERY) ? S_Q_CMP : S_LD_WR;
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      S_LD_WR: begin
        mem_we  = 1'b1;
        cnt_we  = 1'b1;
        stat_d  = STAT_STORED;
        state_d = S_DONE;
      end
      S_Q_SEC: begin
        priority if (sec_end) begin
          stat_d  = STAT_OUTSIDE;
          hit_d   = '0;
          state_d = S_DONE;
        end else if (cnt_rd == '0) begin
          stat_d  = STAT_INSIDE;
          hit_d   = HIT_W'(s_q);
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(base_q);
          ph_d    = '0;
          state_d = S_MAC;
        end
      end
      S_Q_CMP: begin
        priority if (mac_gt) begin
          s_d     = s_q + SCW'(1);
          f_d     = '0;
          base_d  = base_q + BW'(MAX_FACES);
          state_d = S_Q_SEC;
        end else if ((f_q + FCW'(1)) == cnt_rd) begin
          stat_d  = STAT_INSIDE;
          hit_d   = HIT_W'(s_q);
          state_d = S_DONE;
        end else begin
          f_d     = f_q + FCW'(1);
          rd_en   = 1'b1;
          rd_addr = AW'(base_q + BW'(f_q[FW-1:0]) + BW'(1));
          ph_d    = '0;
          state_d = S_MAC;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // face counts, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SECTORS; i++) face_cnt_q[i] <= '0;
    end else if (cnt_we) begin
      face_cnt_q[cnt_idx] <= cnt_rd + FCW'(1);
    end
  end

  // plane store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) plane_mem[wr_addr] <= wr_data;
    if (rd_en)  rd_q <= plane_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q <= stat_q;
      out_hit_q  <= hit_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {(OUT_DATA_W - HIT_W)'(0), out_hit_q};

  // checks
  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_INSIDE) |-> (m_axis_tdata == '0))
    else $error("hit sector set on a result that is not a hit");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !sel_bad && (cnt_rd < FCW'(MAX_FACES)))
    else $error("plane written to a full or missing sector");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) && (func_q == FUNC_QUERY) |-> (f_q < cnt_rd))
    else $error("query tests a face beyond the sector's count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in flight");

endmodule

// ===== tb/tb_point_in_convex_sectors.sv =====
`timescale 1ns / 100ps

module tb_point_in_convex_sectors
  import pics_pkg::*;
();

  localparam int SECTORS         = MAX_SECTORS_DEF;
  localparam int FACES           = MAX_FACES_DEF;
  localparam int CYCLE_LIMIT     = 8_000_000;
  localparam int DRAIN_CYCLES    = 1100;   // longest query plus margin
  localparam int HOLD_CYCLES     = 500;
  localparam int HOLD_AFTER      = 400;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int BOX_FACES       = 6;
  localparam int MAX_ERR_PRINTS  = 40;

  // one predicted result word
  typedef struct packed {
    pics_status_e          status;
    logic [HIT_W-1:0]      hit;
  } sector_answer_t;

  // predictor of the sector table plus the queue of answers still owed
  class sector_hit_scoreboard;
    logic [CNT_W-1:0]        face_cnt [SECTORS];
    logic signed [NRM_W-1:0] nrm_x [SECTORS*FACES];
    logic signed [NRM_W-1:0] nrm_y [SECTORS*FACES];
    logic signed [NRM_W-1:0] nrm_z [SECTORS*FACES];
    logic signed [OFS_W-1:0] plane_ofs [SECTORS*FACES];
    logic [CNT_W-1:0]        search_cnt;
    logic signed [CRD_W-1:0] org_x, org_y, org_z;
    sector_answer_t          pending_answers [$];
    int errors, n_checked, n_stored, n_refused, n_hit, n_missed;

    function new();
      int i;
      for (i = 0; i < SECTORS; i++) face_cnt[i] = '0;
      search_cnt = '0;
      org_x = '0;
      org_y = '0;
      org_z = '0;
      errors = 0;
      n_checked = 0;
      n_stored = 0;
      n_refused = 0;
      n_hit = 0;
      n_missed = 0;
    endfunction

    function void write_reg(pics_cfg_reg_e idx, logic [CRD_W-1:0] value);
      case (idx)
        REG_SECTOR_COUNT: search_cnt = value[CNT_W-1:0];
        REG_ORIGIN_X:     org_x = value;
        REG_ORIGIN_Y:     org_y = value;
        REG_ORIGIN_Z:     org_z = value;
        default: ;
      endcase
    endfunction

    // append a face: keep the normal and its offset n . v
    function sector_answer_t store_face(logic [SEL_W-1:0] sel,
                                        logic signed [NRM_W-1:0] nx, ny, nz,
                                        logic signed [CRD_W-1:0] cx, cy, cz);
      sector_answer_t ans;
      int slot;
      ans.hit = '0;
      if (sel >= SECTORS || face_cnt[sel] >= FACES) begin
        ans.status = STAT_REFUSED;
        return ans;
      end
      slot = int'(sel) * FACES + int'(face_cnt[sel]);
      nrm_x[slot] = nx;
      nrm_y[slot] = ny;
      nrm_z[slot] = nz;
      plane_ofs[slot] = OFS_W'(longint'(nx) * longint'(cx) + longint'(ny) * longint'(cy)
                               + longint'(nz) * longint'(cz));
      face_cnt[sel] = face_cnt[sel] + 1'b1;
      ans.status = STAT_STORED;
      return ans;
    endfunction

    // first sector whose faces all keep the point on the inner side
    function sector_answer_t locate_point(logic signed [CRD_W-1:0] cx, cy, cz);
      sector_answer_t ans;
      longint px, py, pz, dp;
      int lim, s, f, slot;
      bit enclosed;
      px = longint'(cx) - longint'(org_x);
      py = longint'(cy) - longint'(org_y);
      pz = longint'(cz) - longint'(org_z);
      lim = (int'(search_cnt) > SECTORS) ? SECTORS : int'(search_cnt);
      ans.status = STAT_OUTSIDE;
      ans.hit = '0;
      for (s = 0; s < lim; s++) begin
        enclosed = 1'b1;
        for (f = 0; f < int'(face_cnt[s]) && enclosed; f++) begin
          slot = s * FACES + f;
          dp = longint'(nrm_x[slot]) * px + longint'(nrm_y[slot]) * py
             + longint'(nrm_z[slot]) * pz;
          if (dp > longint'(plane_ofs[slot])) enclosed = 1'b0;
        end
        if (enclosed) begin
          ans.status = STAT_INSIDE;
          ans.hit = HIT_W'(s);
          return ans;
        end
      end
      return ans;
    endfunction

    function void note_word(logic func, logic [IN_DATA_W-1:0] data);
      logic [SEL_W-1:0]        sel;
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic signed [CRD_W-1:0] cx, cy, cz;
      sector_answer_t          ans;
      sel = data[3:0];
      nx  = data[21:4];
      ny  = data[39:22];
      nz  = data[57:40];
      cx  = data[81:58];
      cy  = data[105:82];
      cz  = data[129:106];
      if (func == FUNC_LOAD) ans = store_face(sel, nx, ny, nz, cx, cy, cz);
      else ans = locate_point(cx, cy, cz);
      case (ans.status)
        STAT_STORED:  n_stored++;
        STAT_REFUSED: n_refused++;
        STAT_INSIDE:  n_hit++;
        default:      n_missed++;
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void check_word(logic [STAT_W-1:0] status, logic [OUT_DATA_W-1:0] data);
      sector_answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= MAX_ERR_PRINTS)
          $display("%0t: result word with nothing expected: status %0d hit %0d",
                   $time, status, data[3:0]);
        return;
      end
      want = pending_answers.pop_front();
      n_checked++;
      if (status !== want.status) begin
        errors++;
        if (errors <= MAX_ERR_PRINTS)
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (data[3:0] !== want.hit) begin
        errors++;
        if (errors <= MAX_ERR_PRINTS)
          $display("%0t: hit_sector expected %0d actual %0d", $time, want.hit, data[3:0]);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CRD_W-1:0]      cfg_data_i = '0;

  sector_hit_scoreboard sb;

  // box plan per sector: center and half width, Q12.12
  int   box_ctr [SECTORS][3];
  int   half_w [SECTORS];
  int   plan_idx [SECTORS];
  int   cur_org [3];
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  logic rx_hold = 1'b0;
  int   n_sent = 0;
  int   n_settings = 0;
  int   cycle_cnt = 0;

  point_in_convex_sectors u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAIL point_in_convex_sectors");
      $finish;
    end
  end

  // monitors: handshakes sampled at the edge, before any driver update
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_reg(pics_cfg_reg_e'(cfg_addr_i), cfg_data_i);
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_word(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tuser, m_axis_tdata);
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(
      logic [SEL_W-1:0] sel, logic [NRM_W-1:0] nx, ny, nz, logic [CRD_W-1:0] cx, cy, cz);
    return {6'b0, cz, cy, cx, nz, ny, nx, sel};
  endfunction

  // offer one word, with a random gap first while tx_idle is set
  task automatic send_word(logic func, logic [IN_DATA_W-1:0] data);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= func;
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_noise(logic func);
    send_word(func, pack_word(SEL_W'($urandom()), NRM_W'($urandom()), NRM_W'($urandom()),
                              NRM_W'($urandom()), CRD_W'($urandom()), CRD_W'($urandom()),
                              CRD_W'($urandom())));
  endtask

  // next face of a sector: six box sides, then cuts through or near the center
  task automatic load_plan_face(int s);
    logic signed [NRM_W-1:0] nrm [3];
    int vtx [3];
    int k, axis, mag, i;
    bit zero_nrm, shifted;
    k = plan_idx[s];
    plan_idx[s]++;
    if (k < BOX_FACES) begin
      axis = k / 2;
      for (i = 0; i < 3; i++) begin
        nrm[i] = '0;
        vtx[i] = (i == axis) ? box_ctr[s][i] : int'($urandom_range(0, 16777215)) - 8388608;
      end
      mag = ($urandom_range(0, 7) == 0) ? 131071 : int'($urandom_range(1, 131071));
      if (k % 2 == 1) begin
        nrm[axis] = NRM_W'(($urandom_range(0, 7) == 0) ? -131072 : -mag);
        vtx[axis] = box_ctr[s][axis] - half_w[s];
      end else begin
        nrm[axis] = NRM_W'(mag);
        vtx[axis] = box_ctr[s][axis] + half_w[s];
      end
    end else begin
      zero_nrm = ($urandom_range(0, 7) == 0);
      shifted  = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 3; i++) begin
        nrm[i] = zero_nrm ? '0 : NRM_W'($urandom());
        vtx[i] = box_ctr[s][i];
        if (shifted) vtx[i] += int'($urandom_range(0, half_w[s] / 2)) - half_w[s] / 4;
      end
    end
    send_word(FUNC_LOAD, pack_word(SEL_W'(s), nrm[0], nrm[1], nrm[2],
                                   CRD_W'(vtx[0]), CRD_W'(vtx[1]), CRD_W'(vtx[2])));
  endtask

  // point at, inside or just around a sector's box
  task automatic query_near(int s);
    logic [CRD_W-1:0] crd [3];
    int r, h, i;
    r = $urandom_range(0, 9);
    h = (r < 7) ? half_w[s] / 2 : half_w[s] + half_w[s] / 2;
    for (i = 0; i < 3; i++) begin
      if (r < 2) crd[i] = CRD_W'(cur_org[i] + box_ctr[s][i]);
      else crd[i] = CRD_W'(cur_org[i] + box_ctr[s][i] + int'($urandom_range(0, 2 * h)) - h);
    end
    send_word(FUNC_QUERY, pack_word(SEL_W'($urandom()), NRM_W'($urandom()),
                                    NRM_W'($urandom()), NRM_W'($urandom()),
                                    crd[0], crd[1], crd[2]));
  endtask

  // let the block drain: every owed result back, then a short pause
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.n_checked < n_sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_config(int cnt_val, int ox, int oy, int oz);
    pics_cfg_reg_e    regs [4];
    logic [CRD_W-1:0] vals [4];
    int i;
    regs[0] = REG_SECTOR_COUNT;
    regs[1] = REG_ORIGIN_X;
    regs[2] = REG_ORIGIN_Y;
    regs[3] = REG_ORIGIN_Z;
    // upper bits of the count word are don't-care
    vals[0] = {19'($urandom()), 5'(cnt_val)};
    vals[1] = CRD_W'(ox);
    vals[2] = CRD_W'(oy);
    vals[3] = CRD_W'(oz);
    cur_org[0] = ox;
    cur_org[1] = oy;
    cur_org[2] = oz;
    for (i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // result side: random stall per word while rx_idle is set, long hold when requested
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = rx_idle ? $urandom_range(0, 4) : 0;
      if (w > 0 || rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // back-pressure burst: output blocked while the input keeps offering
  initial begin
    @(posedge rst_ni);
    while (sb.n_checked < HOLD_AFTER) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    int s, k, ph, n, r, cnt_val;
    int org [3];
    sb = new();
    for (s = 0; s < SECTORS; s++) begin
      for (k = 0; k < 3; k++) box_ctr[s][k] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      half_w[s]   = $urandom_range(256, 1 << 20);
      plan_idx[s] = 0;
    end
    cur_org[0] = 0;
    cur_org[1] = 0;
    cur_org[2] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config searches no sector
    send_word(FUNC_QUERY, pack_word('0, '0, '0, '0, '0, '0, '0));
    send_word(FUNC_QUERY, pack_word('1, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                                    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    // one empty sector holds every point, extreme origin and coords
    wait_idle();
    set_config(1, -8388608, 8388607, 0);
    send_word(FUNC_QUERY, pack_word('0, '0, '0, '0, 24'h800000, 24'h800000, 24'h800000));
    send_word(FUNC_QUERY, pack_word('0, '0, '0, '0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    // extreme loads into the last sectors, plus a zero normal
    send_word(FUNC_LOAD, pack_word(4'd15, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                                   24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_word(FUNC_LOAD, pack_word(4'd15, 18'h20000, 18'h20000, 18'h20000,
                                   24'h800000, 24'h800000, 24'h800000));
    send_word(FUNC_LOAD, pack_word(4'd15, 18'h00001, '0, 18'h3FFFF,
                                   24'h7FFFFF, '0, 24'h800000));
    send_word(FUNC_LOAD, pack_word(4'd14, '0, '0, '0, CRD_W'($urandom()),
                                   CRD_W'($urandom()), CRD_W'($urandom())));
    // count beyond the table size
    wait_idle();
    set_config(31, 8388607, -8388608, 8388607);
    send_word(FUNC_QUERY, pack_word('0, '0, '0, '0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
    send_word(FUNC_QUERY, pack_word('1, '1, '1, '1, 24'h800000, 24'h7FFFFF, 24'h800000));
    wait_idle();
    set_config(0, 0, 0, 0);
    send_noise(FUNC_QUERY);
    send_noise(FUNC_LOAD);

    // random phases over several table settings
    for (ph = 0; ph < 8; ph++) begin
      for (k = 0; k < 3; k++) begin
        case (ph)
          0, 6:    org[k] = 0;
          1, 5:    org[k] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
          2:       org[k] = 8388607;
          3:       org[k] = -8388608;
          default: org[k] = int'($urandom_range(0, 16777215)) - 8388608;
        endcase
      end
      case (ph)
        2:       cnt_val = 31;
        4:       cnt_val = 0;
        5:       cnt_val = $urandom_range(1, 15);
        7:       cnt_val = $urandom_range(0, 31);
        default: cnt_val = SECTORS;
      endcase
      tx_idle = !(ph == 3 || ph == 6);
      rx_idle = tx_idle;
      wait_idle();
      set_config(cnt_val, org[0], org[1], org[2]);
      n = 0;
      // first build a box around every sector
      if (ph == 0) begin
        for (s = 0; s < SECTORS; s++) begin
          for (k = 0; k < BOX_FACES; k++) load_plan_face(s);
        end
        n = SECTORS * BOX_FACES;
      end
      for (; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_noise(1'($urandom_range(0, 1)));
        else if (r < 20) load_plan_face($urandom_range(0, SECTORS - 1));
        else if (r < 90) query_near($urandom_range(0, SECTORS - 1));
        else send_noise(FUNC_QUERY);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_answers.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected result words never arrived",
               $time, sb.pending_answers.size());
    end
    $display("Sent %0d words over %0d table settings: %0d faces stored, %0d loads refused",
             n_sent, n_settings, sb.n_stored, sb.n_refused);
    $display("Queries: %0d points found in a sector, %0d outside all; %0d errors",
             sb.n_hit, sb.n_missed, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS point_in_convex_sectors");
    end else begin
      $display("FAIL point_in_convex_sectors");
    end
    $finish;
  end

endmodule
